/* hdl/minute_tagged_sample_ring_defines.svh */
// assertion macros for the minute tagged sample ring
`ifndef MINUTE_TAGGED_SAMPLE_RING_DEFINES_SVH
`define MINUTE_TAGGED_SAMPLE_RING_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MTSR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtsr: same-cycle check failed");

// next-cycle implication, disabled during reset
`define MTSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtsr: next-cycle check failed");

`endif

/* hdl/mtsr_pkg.sv */
package mtsr_pkg;

   localparam logic [1:0] REQ_ADVANCE = 2'd0;
   localparam logic [1:0] REQ_PUT     = 2'd1;
   localparam logic [1:0] REQ_GET     = 2'd2;

   localparam logic [1:0] ORG_EMPTY    = 2'd0;
   localparam logic [1:0] ORG_BACKFILL = 2'd1;
   localparam logic [1:0] ORG_LOCAL    = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] minute;
      logic [7:0]  sample_bpm;
      logic        sample_source;
   } mtsr_req_type;

   typedef struct packed {
      logic       accepted;
      logic [7:0] read_bpm;
      logic       read_source;
   } mtsr_rsp_type;

   typedef struct packed {
      logic [31:0] tag;
      logic [7:0]  rate;
      logic [1:0]  origin;
   } mtsr_entry_type;

   typedef struct packed {
      logic        borrow;
      logic        zero;
      logic [31:0] diff;
   } mtsr_alu_res_type;

endpackage

/* hdl/mtsr_ram.sv */
module mtsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/mtsr_alu.sv */
module mtsr_alu (
   input  logic [31:0]               op_a,
   input  logic [31:0]               op_b,
   output mtsr_pkg::mtsr_alu_res_type res
);

   import mtsr_pkg::*;

   logic [32:0] wide;

   // a - b with borrow out
   assign wide       = {1'b0, op_a} - {1'b0, op_b};
   assign res.borrow = wide[32];
   assign res.diff   = wide[31:0];
   assign res.zero   = (wide[31:0] == 32'd0);

endmodule

/* hdl/minute_tagged_sample_ring.sv */
// channel      | ports                      | handshake
// request      | start, busy, req_data      | taken when start high and busy low
// response     | rsp_strobe, rsp_data       | one-cycle strobe, no back-pressure
//
// state path, get: eval, read, check, or eval alone out of window; advance: eval,
// then gap unless first or older, then a clear step per slot cleared (gap, or SLOTS
// on a jump of SLOTS or more); put: eval alone if rejected early, else eval, read,
// check, with gap and clears between when it moves the newest minute. window, gap
// and tag compares share one 32-bit subtractor; clears and lookups go through the
// ring ram. after reset a clearing pass over all SLOTS runs with busy high. the
// receiver cannot stall: each result shows for one cycle.
`include "minute_tagged_sample_ring_defines.svh"

module minute_tagged_sample_ring #(
   parameter int SLOTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mtsr_pkg::mtsr_req_type req_data,
   output logic                  rsp_strobe,
   output mtsr_pkg::mtsr_rsp_type rsp_data
);

   import mtsr_pkg::*;

   localparam int AW = $clog2(SLOTS);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EVAL  = 6'b000010,
      ST_GAP   = 6'b000100,
      ST_CLEAR = 6'b001000,
      ST_READ  = 6'b010000,
      ST_CHECK = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   mtsr_req_type     req_ff, req_in;
   mtsr_rsp_type     rsp_ff, rsp_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic             have_ff, have_in;
   logic [31:0]      newest_ff, newest_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [AW:0]      remain_ff, remain_in;
   logic             boot_ff, boot_in;

   logic [31:0]      alu_a, alu_b;
   mtsr_alu_res_type alu_res;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   mtsr_entry_type   ram_wdata;
   logic [$bits(mtsr_entry_type)-1:0] ram_rdata;
   mtsr_entry_type   rd_entry;

   logic             in_window;
   logic             put_reject;

   function automatic mtsr_rsp_type make_rsp(logic ok, logic [7:0] bpm, logic src);
      mtsr_rsp_type r;
      r.accepted    = ok;
      r.read_bpm    = bpm;
      r.read_source = src;
      return r;
   endfunction

   mtsr_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   mtsr_ram #(
      .WIDTH ($bits(mtsr_entry_type)),
      .DEPTH (SLOTS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (req_ff.minute[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign rd_entry = mtsr_entry_type'(ram_rdata);

   always_comb begin
      case (state_ff)
         ST_GAP: begin
            alu_a = req_ff.minute;
            alu_b = newest_ff;
         end
         ST_CHECK: begin
            alu_a = rd_entry.tag;
            alu_b = req_ff.minute;
         end
         default: begin
            alu_a = newest_ff;
            alu_b = req_ff.minute;
         end
      endcase
   end

   // newest - minute with no borrow and below SLOTS
   assign in_window  = have_ff && !alu_res.borrow && (alu_res.diff[31:AW] == '0);
   // local slot with matching tag refuses a backfill
   assign put_reject = (rd_entry.origin == ORG_LOCAL) && alu_res.zero &&
                       !req_ff.sample_source;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      have_in       = have_ff;
      newest_in     = newest_ff;
      addr_in       = addr_ff;
      remain_in     = remain_ff;
      boot_in       = boot_ff;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff;
      ram_wdata     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_EVAL;
            end
         end

         ST_EVAL: begin
            case (req_ff.req_type)
               REQ_ADVANCE: begin
                  if (!have_ff) begin
                     have_in       = 1'b1;
                     newest_in     = req_ff.minute;
                     rsp_in        = make_rsp(1'b1, 8'd0, 1'b0);
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end else if (!alu_res.borrow && !alu_res.zero) begin
                     rsp_in        = make_rsp(1'b0, 8'd0, 1'b0);
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     state_in = ST_GAP;
                  end
               end
               REQ_PUT: begin
                  if (req_ff.sample_bpm == 8'd0) begin
                     rsp_in        = make_rsp(1'b0, 8'd0, 1'b0);
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end else if (!have_ff) begin
                     have_in   = 1'b1;
                     newest_in = req_ff.minute;
                     state_in  = ST_READ;
                  end else if (alu_res.borrow) begin
                     state_in = ST_GAP;
                  end else if (in_window) begin
                     state_in = ST_READ;
                  end else begin
                     rsp_in        = make_rsp(1'b0, 8'd0, 1'b0);
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               REQ_GET: begin
                  if (in_window) begin
                     state_in = ST_READ;
                  end else begin
                     rsp_in        = make_rsp(1'b0, 8'd0, 1'b0);
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               default: begin
                  rsp_in        = make_rsp(1'b0, 8'd0, 1'b0);
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            endcase
         end

         ST_GAP: begin
            newest_in = req_ff.minute;
            if (alu_res.zero) begin
               if (req_ff.req_type == REQ_PUT) begin
                  state_in = ST_READ;
               end else begin
                  rsp_in        = make_rsp(1'b1, 8'd0, 1'b0);
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (alu_res.diff[31:AW] != '0) begin
               addr_in   = '0;
               remain_in = (AW+1)'(SLOTS);
               state_in  = ST_CLEAR;
            end else begin
               addr_in   = newest_ff[AW-1:0] + AW'(1);
               remain_in = {1'b0, alu_res.diff[AW-1:0]};
               state_in  = ST_CLEAR;
            end
         end

         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            addr_in   = addr_ff + AW'(1);
            remain_in = remain_ff - (AW+1)'(1);
            if (remain_ff == (AW+1)'(1)) begin
               if (boot_ff) begin
                  boot_in  = 1'b0;
                  state_in = ST_IDLE;
               end else if (req_ff.req_type == REQ_PUT) begin
                  state_in = ST_READ;
               end else begin
                  rsp_in        = make_rsp(1'b1, 8'd0, 1'b0);
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end

         ST_READ: begin
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (req_ff.req_type == REQ_PUT) begin
               if (put_reject) begin
                  rsp_in = make_rsp(1'b0, 8'd0, 1'b0);
               end else begin
                  ram_we           = 1'b1;
                  ram_waddr        = req_ff.minute[AW-1:0];
                  ram_wdata.tag    = req_ff.minute;
                  ram_wdata.rate   = req_ff.sample_bpm;
                  ram_wdata.origin = req_ff.sample_source ? ORG_LOCAL : ORG_BACKFILL;
                  rsp_in           = make_rsp(1'b1, 8'd0, 1'b0);
               end
            end else if ((rd_entry.origin != ORG_EMPTY) && alu_res.zero &&
                         (rd_entry.rate != 8'd0)) begin
               rsp_in = make_rsp(1'b1, rd_entry.rate, rd_entry.origin == ORG_LOCAL);
            end else begin
               rsp_in = make_rsp(1'b0, 8'd0, 1'b0);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rsp_strobe_ff <= 1'b0;
         have_ff       <= 1'b0;
         newest_ff     <= 32'd0;
         addr_ff       <= '0;
         remain_ff     <= (AW+1)'(SLOTS);
         boot_ff       <= 1'b1;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         have_ff       <= have_in;
         newest_ff     <= newest_in;
         addr_ff       <= addr_in;
         remain_ff     <= remain_in;
         boot_ff       <= boot_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `MTSR_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `MTSR_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)
   `MTSR_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == ST_IDLE, !ram_we)
   `MTSR_ASSERT_NEXT(a_newest_sticky, clock, reset, have_ff, have_ff)
   `MTSR_ASSERT_NOW(a_clear_count, clock, reset, state_ff == ST_CLEAR, remain_ff != '0)

endmodule

/* tb/testbench.sv */
module testbench;
   import mtsr_pkg::*;

   localparam int RING_SLOTS = 64;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 1850;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   class sample_ring_checker_type;
      logic [31:0]  slot_tag [RING_SLOTS];
      logic [7:0]   slot_rate [RING_SLOTS];
      logic [1:0]   slot_origin [RING_SLOTS];
      bit           have_newest;
      logic [31:0]  newest;
      mtsr_rsp_type pending_replies[$];
      int           errors;

      function new();
         wipe_ring();
         have_newest = 1'b0;
         newest = '0;
         errors = 0;
      endfunction

      function void clear_slot(logic [31:0] m);
         int i;
         i = int'(m % RING_SLOTS);
         slot_tag[i] = '0;
         slot_rate[i] = '0;
         slot_origin[i] = ORG_EMPTY;
      endfunction

      function void wipe_ring();
         for (int i = 0; i < RING_SLOTS; i++) begin
            slot_tag[i] = '0;
            slot_rate[i] = '0;
            slot_origin[i] = ORG_EMPTY;
         end
      endfunction

      function bit advance_to(logic [31:0] m);
         logic [31:0] gap;
         if (!have_newest) begin
            have_newest = 1'b1;
            newest = m;
            return 1'b1;
         end
         if (m < newest) return 1'b0;
         gap = m - newest;
         if (gap >= RING_SLOTS) begin
            wipe_ring();
         end else begin
            for (logic [31:0] k = 1; k <= gap; k++) clear_slot(newest + k);
         end
         newest = m;
         return 1'b1;
      endfunction

      function bit in_window(logic [31:0] m);
         return have_newest && m <= newest && (newest - m) < RING_SLOTS;
      endfunction

      function bit store_sample(logic [31:0] m, logic [7:0] bpm, logic src);
         int         i;
         logic [1:0] org;
         if (bpm == 0) return 1'b0;
         if (!have_newest || m > newest) void'(advance_to(m));
         if (!in_window(m)) return 1'b0;
         i = int'(m % RING_SLOTS);
         if (slot_origin[i] != ORG_EMPTY && slot_tag[i] != m) clear_slot(m);
         org = src ? ORG_LOCAL : ORG_BACKFILL;
         if (slot_origin[i] == ORG_LOCAL && org == ORG_BACKFILL) return 1'b0;
         slot_tag[i] = m;
         slot_rate[i] = bpm;
         slot_origin[i] = org;
         return 1'b1;
      endfunction

      function void note_request(mtsr_req_type r);
         mtsr_rsp_type e;
         int           i;
         e = '0;
         i = int'(r.minute % RING_SLOTS);
         case (r.req_type)
            REQ_ADVANCE: begin
               e.accepted = advance_to(r.minute);
            end
            REQ_PUT: begin
               e.accepted = store_sample(r.minute, r.sample_bpm, r.sample_source);
            end
            REQ_GET: begin
               if (in_window(r.minute) && slot_origin[i] != ORG_EMPTY &&
                   slot_tag[i] == r.minute && slot_rate[i] != 0) begin
                  e.accepted = 1'b1;
                  e.read_bpm = slot_rate[i];
                  e.read_source = (slot_origin[i] == ORG_LOCAL);
               end
            end
            default: ;
         endcase
         pending_replies.push_back(e);
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_reply(mtsr_rsp_type got);
         mtsr_rsp_type e;
         if (pending_replies.size() == 0) begin
            report($sformatf("response %h with nothing outstanding", got));
            return;
         end
         e = pending_replies.pop_front();
         if (got.accepted !== e.accepted)
            report($sformatf("accepted %b, expected %b", got.accepted, e.accepted));
         if (got.read_bpm !== e.read_bpm)
            report($sformatf("read_bpm %h, expected %h", got.read_bpm, e.read_bpm));
         if (got.read_source !== e.read_source)
            report($sformatf("read_source %b, expected %b", got.read_source, e.read_source));
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   mtsr_req_type req_data;
   logic         rsp_strobe;
   mtsr_rsp_type rsp_data;

   sample_ring_checker_type sb = new();
   int  idle_cycles;
   bit  quiet;

   minute_tagged_sample_ring #(.SLOTS(RING_SLOTS)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_data);
         if (rsp_strobe === 1'b1) sb.check_reply(rsp_data);
      end
   end

   // stall watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic mtsr_req_type mk(logic [1:0] t, logic [31:0] m, logic [7:0] bpm,
                                       logic src);
      mtsr_req_type r;
      r.req_type = t;
      r.minute = m;
      r.sample_bpm = bpm;
      r.sample_source = src;
      return r;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (quiet || p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send(mtsr_req_type r);
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic pause(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic issue(mtsr_req_type r);
      send(r);
      pause(gap_len());
   endtask

   // hold off until every outstanding transaction has answered
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic random_item(inout logic [31:0] head);
      mtsr_req_type r;
      int           p;
      int           w;
      p = $urandom_range(0, 99);
      w = $urandom_range(0, 99);
      r.req_type = (p < 30) ? REQ_ADVANCE : (p < 70) ? REQ_PUT : (p < 97) ? REQ_GET : REQ_UNUSED;
      if (w < 55) r.minute = head - 32'($urandom_range(0, 70));
      else if (w < 75) r.minute = head + 32'($urandom_range(0, 8));
      else if (w < 82) r.minute = head + 32'($urandom_range(60, 70));
      else if (w < 85) r.minute = head + 32'($urandom_range(71, 400));
      else if (w < 88) r.minute = head + 32'($urandom_range(0, 65536));
      else if (r.req_type == REQ_GET && w >= 97) r.minute = $urandom;
      else r.minute = $urandom % (head + 1);
      r.sample_bpm = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      r.sample_source = 1'($urandom_range(0, 1));
      if ((r.req_type == REQ_ADVANCE || (r.req_type == REQ_PUT && r.sample_bpm != 0)) &&
          r.minute > head)
         head = r.minute;
      issue(r);
   endtask

   initial begin
      logic [31:0] head;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      quiet = 1'b0;
      idle_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // no newest minute yet
      issue(mk(REQ_GET, 32'd0, 8'd0, 1'b0));
      issue(mk(REQ_PUT, 32'd200, 8'd0, 1'b1));
      issue(mk(REQ_UNUSED, 32'hA5A5_5A5A, 8'hC3, 1'b1));
      issue(mk(REQ_PUT, 32'd200, 8'hFF, 1'b1));
      issue(mk(REQ_GET, 32'd200, 8'd0, 1'b0));
      // backfill over local, then local overwrite
      issue(mk(REQ_PUT, 32'd200, 8'd9, 1'b0));
      issue(mk(REQ_PUT, 32'd200, 8'd1, 1'b1));
      issue(mk(REQ_ADVANCE, 32'd150, 8'd0, 1'b0));
      issue(mk(REQ_ADVANCE, 32'd200, 8'd0, 1'b0));
      // window edges
      issue(mk(REQ_PUT, 32'd136, 8'd3, 1'b0));
      issue(mk(REQ_PUT, 32'd137, 8'h80, 1'b0));
      issue(mk(REQ_GET, 32'd137, 8'd0, 1'b0));
      // newer put wraps onto the same slot
      issue(mk(REQ_PUT, 32'd201, 8'h42, 1'b1));
      issue(mk(REQ_GET, 32'd137, 8'd0, 1'b0));
      issue(mk(REQ_GET, 32'd201, 8'd0, 1'b0));
      issue(mk(REQ_ADVANCE, 32'd264, 8'd0, 1'b0));
      issue(mk(REQ_GET, 32'd201, 8'd0, 1'b0));
      issue(mk(REQ_PUT, 32'd300, 8'h7F, 1'b0));
      // jump clears the whole ring
      issue(mk(REQ_ADVANCE, 32'd400, 8'd0, 1'b0));
      issue(mk(REQ_GET, 32'd300, 8'd0, 1'b0));
      issue(mk(REQ_GET, 32'd380, 8'd0, 1'b0));
      issue(mk(REQ_PUT, 32'd399, 8'hFE, 1'b1));
      issue(mk(REQ_GET, 32'd399, 8'd0, 1'b0));
      drain();

      head = 32'd5000;
      issue(mk(REQ_ADVANCE, head, 8'd0, 1'b0));
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (n % 300 == 299) drain();
         random_item(head);
      end
      quiet = 1'b0;

      // top of the minute range
      issue(mk(REQ_ADVANCE, 32'hFFFF_FFFF, 8'd0, 1'b0));
      issue(mk(REQ_PUT, 32'hFFFF_FFFF, 8'hAA, 1'b1));
      issue(mk(REQ_PUT, 32'hFFFF_FFC0, 8'h55, 1'b0));
      issue(mk(REQ_PUT, 32'hFFFF_FFBF, 8'h11, 1'b1));
      issue(mk(REQ_GET, 32'hFFFF_FFC0, 8'd0, 1'b0));
      issue(mk(REQ_GET, 32'hFFFF_FFFF, 8'd0, 1'b0));
      issue(mk(REQ_GET, 32'd0, 8'd0, 1'b0));
      issue(mk(REQ_ADVANCE, 32'hFFFF_FFFE, 8'd0, 1'b0));
      issue(mk(REQ_ADVANCE, 32'd0, 8'd0, 1'b0));

      drain();
      repeat (100) @(posedge clock);
      if (sb.pending_replies.size() != 0)
         sb.report($sformatf("%0d transactions never answered", sb.pending_replies.size()));
      if (sb.errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule

/* filelist.f */
+incdir+hdl
hdl/mtsr_pkg.sv
hdl/mtsr_ram.sv
hdl/mtsr_alu.sv
hdl/minute_tagged_sample_ring.sv
tb/testbench.sv
